// File: rtl/mqpd_pkg.sv
// Shared types and codes for the multi-queue priority dispatcher.
`timescale 1ns / 1ps

package mqpd_pkg;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam int JOB_NUM_W = 32;

  // Input word
  typedef struct packed {
    logic       command;
    logic [2:0] queue_select;
    logic [3:0] job_priority;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [1:0]           status;
    logic [JOB_NUM_W-1:0] job_number;
  } out_word_t;

  // Controls for the best-entry picker
  typedef struct packed {
    logic clear;
    logic load;
  } pick_ctrl_t;

endpackage

// File: rtl/mqpd_pick.sv
// Shared compare unit: keeps the best candidate entry seen during a scan.
`timescale 1ns / 1ps

module mqpd_pick #(
  parameter int IW = 4,
  parameter int PW = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mqpd_pkg::pick_ctrl_t          ctrl,
  input  logic                          cand_valid,
  input  logic [IW-1:0]                 cand_idx,
  input  logic [PW-1:0]                 cand_prio,
  input  logic [mqpd_pkg::JOB_NUM_W-1:0] cand_num,
  output logic                          best_found,
  output logic [IW-1:0]                 best_idx,
  output logic [mqpd_pkg::JOB_NUM_W-1:0] best_num
);

  logic                           found_r;
  logic [IW-1:0]                  idx_r;
  logic [PW-1:0]                  prio_r;
  logic [mqpd_pkg::JOB_NUM_W-1:0] num_r;
  logic                           take;

  // Take a valid candidate with higher priority, or equal priority and earlier arrival
  always_comb begin
    take = ctrl.load && cand_valid &&
           (!found_r || (cand_prio > prio_r) ||
            ((cand_prio == prio_r) && (cand_num < num_r)));
  end

  // Hold the found flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctrl.clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  // Hold the best entry payload
  always_ff @(posedge clk) begin
    if (take) begin
      idx_r  <= cand_idx;
      prio_r <= cand_prio;
      num_r  <= cand_num;
    end
  end

  assign best_found = found_r;
  assign best_idx   = idx_r;
  assign best_num   = num_r;

endmodule

// File: rtl/multi_queue_priority_dispatch.sv
// Top level: several priority queues with a shared arrival counter.
//
// Usage: drive in_word and raise start; the word is taken at a clock edge
// where start is high and busy is low. Every word gives exactly one result
// word on out_word, marked by out_valid for a single cycle; the receiver
// must take it then, there is no back-pressure.
// Insert (command 0): the job is stored in the selected queue and gets the
// next arrival number (first is 1, wraps modulo 2^32). The free slot is found
// by walking the queue's valid bits one per cycle. A full queue or an
// out-of-range queue answers status 3 in the cycle after acceptance.
// Remove (command 1): one memory read port walks all QUEUE_DEPTH slots of the
// queue, one per cycle, feeding a single comparator; a drain state and a done
// state follow, and the result strobe is registered after the done state. An
// out-of-range queue answers status 2 in the cycle after acceptance.
// busy is high only while a word scans, until its result cycle; one word at a time.
// Reset (synchronous, rst_n low) empties all queues and sets the counter to 1;
// the entry memory itself is not cleared, only its valid bits.
`timescale 1ns / 1ps

module multi_queue_priority_dispatch #(
  parameter int NUM_QUEUES    = 5,
  parameter int QUEUE_DEPTH   = 16,
  parameter int PRIORITY_BITS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mqpd_pkg::in_word_t  in_word,
  output logic                out_valid,
  output mqpd_pkg::out_word_t out_word
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = PRIORITY_BITS;
  localparam int NW = mqpd_pkg::JOB_NUM_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_INS   = 5'b00010,
    S_REM   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic [PW-1:0] prio;
    logic [NW-1:0] num;
  } entry_t;

  state_t                              state_r, state_nxt;
  logic [QW-1:0]                       q_r, q_nxt;
  logic [PW-1:0]                       prio_r, prio_nxt;
  logic [IW-1:0]                       idx_r, idx_nxt;
  logic [NW-1:0]                       arrival_r, arrival_nxt;
  logic                                out_valid_r, out_valid_nxt;
  mqpd_pkg::out_word_t                 out_word_r, out_word_nxt;
  logic [NUM_QUEUES-1:0][QUEUE_DEPTH-1:0] valid_r;
  logic [NUM_QUEUES-1:0][FW-1:0]       fill_r;
  entry_t                              mem_r [NUM_QUEUES][QUEUE_DEPTH];
  entry_t                              rd_data_r;
  logic                                rd_pend_r;
  logic                                rd_valid_r;
  logic [IW-1:0]                       rd_idx_r;

  logic                                accept;
  logic [QW-1:0]                       in_q;
  logic                                in_range;
  logic                                in_full;
  logic                                idx_last;
  logic                                wr_en;
  logic                                v_set, v_clr;
  logic                                fill_inc, fill_dec;
  mqpd_pkg::pick_ctrl_t                pick_ctrl;
  logic                                best_found;
  logic [IW-1:0]                       best_idx;
  logic [NW-1:0]                       best_num;

  assign accept   = start && !busy;
  assign in_q     = QW'(in_word.queue_select);
  assign in_range = ({29'd0, in_word.queue_select} < 32'(NUM_QUEUES));
  assign in_full  = in_range && (fill_r[in_q] >= FW'(QUEUE_DEPTH));
  assign idx_last = (idx_r == IW'(QUEUE_DEPTH - 1));

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    q_nxt         = q_r;
    prio_nxt      = prio_r;
    idx_nxt       = idx_r;
    arrival_nxt   = arrival_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    wr_en         = 1'b0;
    v_set         = 1'b0;
    v_clr         = 1'b0;
    fill_inc      = 1'b0;
    fill_dec      = 1'b0;
    pick_ctrl     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          q_nxt    = in_q;
          prio_nxt = PW'(in_word.job_priority);
          idx_nxt  = '0;
          if (in_word.command == mqpd_pkg::CMD_INSERT) begin
            if (!in_range || in_full) begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = '{status: mqpd_pkg::ST_FULL, job_number: '0};
            end else begin
              state_nxt = S_INS;
            end
          end else begin
            if (!in_range) begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = '{status: mqpd_pkg::ST_EMPTY, job_number: '0};
            end else begin
              pick_ctrl.clear = 1'b1;
              state_nxt       = S_REM;
            end
          end
        end
      end
      S_INS: begin
        // Walk the valid bits until a free slot turns up
        if (!valid_r[q_r][idx_r]) begin
          wr_en         = 1'b1;
          v_set         = 1'b1;
          fill_inc      = 1'b1;
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{status: mqpd_pkg::ST_INSERTED, job_number: arrival_r};
          arrival_nxt   = arrival_r + NW'(1);
          state_nxt     = S_IDLE;
        end else if (idx_last) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{status: mqpd_pkg::ST_FULL, job_number: '0};
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_REM: begin
        // Issue one read per cycle; compare the previous one
        pick_ctrl.load = rd_pend_r;
        if (idx_last) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_DRAIN: begin
        pick_ctrl.load = rd_pend_r;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        if (best_found) begin
          v_clr        = 1'b1;
          fill_dec     = 1'b1;
          out_word_nxt = '{status: mqpd_pkg::ST_REMOVED, job_number: best_num};
        end else begin
          out_word_nxt = '{status: mqpd_pkg::ST_EMPTY, job_number: '0};
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      arrival_r   <= NW'(1);
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      arrival_r   <= arrival_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= (state_r == S_REM);
    end
  end

  // Hold item payload and scan position
  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    prio_r     <= prio_nxt;
    idx_r      <= idx_nxt;
    out_word_r <= out_word_nxt;
    rd_idx_r   <= idx_r;
    rd_valid_r <= valid_r[q_r][idx_r];
  end

  // Set and drop valid bits, track fill counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fill_r  <= '0;
    end else begin
      if (v_set) begin
        valid_r[q_r][idx_r] <= 1'b1;
      end
      if (v_clr) begin
        valid_r[q_r][best_idx] <= 1'b0;
      end
      if (fill_inc) begin
        fill_r[q_r] <= fill_r[q_r] + FW'(1);
      end else if (fill_dec && (fill_r[q_r] != '0)) begin
        fill_r[q_r] <= fill_r[q_r] - FW'(1);
      end
    end
  end

  // Entry memory write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[q_r][idx_r] <= '{prio: prio_r, num: arrival_r};
    end
  end

  // Entry memory read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[q_r][idx_r];
  end

  mqpd_pick #(
    .IW(IW),
    .PW(PW)
  ) u_pick (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (pick_ctrl),
    .cand_valid (rd_valid_r),
    .cand_idx   (rd_idx_r),
    .cand_prio  (rd_data_r.prio),
    .cand_num   (rd_data_r.num),
    .best_found (best_found),
    .best_idx   (best_idx),
    .best_num   (best_num)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: tb/multi_queue_priority_dispatch_tb.sv
// Testbench for the multi-queue priority dispatcher: directed and random words, checked result by result.
`timescale 1ns / 1ps

module multi_queue_priority_dispatch_tb;

  localparam int NQ         = 5;
  localparam int DEPTH      = 16;
  localparam int RAND_WORDS = 1800;
  localparam int IDLE_LIMIT = 5000;
  localparam int RUN_LIMIT  = 400000;
  localparam int DRAIN_WAIT = 40;

  typedef struct {
    mqpd_pkg::in_word_t word;
    bit                 drain;
  } feed_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  mqpd_pkg::in_word_t  in_word;
  logic                out_valid;
  mqpd_pkg::out_word_t out_word;

  multi_queue_priority_dispatch dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // Shadow of the queues and the arrival counter
  bit          slot_used [NQ][DEPTH];
  logic [3:0]  slot_prio [NQ][DEPTH];
  logic [31:0] slot_num  [NQ][DEPTH];
  int unsigned queue_count [NQ];
  logic [31:0] next_arrival;

  feed_t               feed_q[$];
  mqpd_pkg::out_word_t result_due[$];
  int                  words_total;
  int                  words_taken;
  int                  words_offered;
  int                  mismatches;
  int                  n_inserted, n_removed, n_empty, n_full;
  int                  quiet_cycles;
  int                  cycles_run;
  bit                  taken;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Work out the result of one word and update the shadow state
  function automatic mqpd_pkg::out_word_t dispatch_predict(input mqpd_pkg::in_word_t w);
    mqpd_pkg::out_word_t r;
    int                  q;
    int                  best;
    bit                  found;
    r.status     = mqpd_pkg::ST_EMPTY;
    r.job_number = '0;
    q            = int'(w.queue_select);
    best         = 0;
    found        = 1'b0;
    if (w.command == mqpd_pkg::CMD_INSERT) begin
      r.status = mqpd_pkg::ST_FULL;
      if (q < NQ && queue_count[q] < DEPTH) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (!found && !slot_used[q][i]) begin
            found           = 1'b1;
            slot_used[q][i] = 1'b1;
            slot_prio[q][i] = w.job_priority;
            slot_num[q][i]  = next_arrival;
          end
        end
        if (found) begin
          queue_count[q]++;
          r.status     = mqpd_pkg::ST_INSERTED;
          r.job_number = next_arrival;
          next_arrival = next_arrival + 32'd1;
        end
      end
    end else if (q < NQ) begin
      // Highest priority wins, earliest arrival breaks a tie
      for (int i = 0; i < DEPTH; i++) begin
        if (slot_used[q][i]) begin
          if (!found || slot_prio[q][i] > slot_prio[q][best] ||
              (slot_prio[q][i] == slot_prio[q][best] &&
               slot_num[q][i] < slot_num[q][best])) begin
            best  = i;
            found = 1'b1;
          end
        end
      end
      if (found) begin
        slot_used[q][best] = 1'b0;
        if (queue_count[q] > 0) queue_count[q]--;
        r.status     = mqpd_pkg::ST_REMOVED;
        r.job_number = slot_num[q][best];
      end
    end
    return r;
  endfunction

  function automatic mqpd_pkg::in_word_t make_word(input logic cmd, input int q, input int prio);
    mqpd_pkg::in_word_t w;
    w.command      = cmd;
    w.queue_select = q[2:0];
    w.job_priority = prio[3:0];
    return w;
  endfunction

  task automatic queue_word(input logic cmd, input int q, input int prio, input bit drain);
    feed_t f;
    f.word  = make_word(cmd, q, prio);
    f.drain = drain;
    feed_q  = {feed_q, f};
  endtask

  // Pick a queue, mostly a real one, sometimes one that does not exist
  function automatic int pick_queue();
    if ($urandom_range(0, 19) == 0) return $urandom_range(NQ, 7);
    return $urandom_range(0, NQ - 1);
  endfunction

  // Fill the stimulus: directed words first, then random bursts
  task automatic build_stimulus();
    int  q;
    int  len;
    int  mode;
    int  round;
    bit  tie_prio;
    // Empty queue, and removes from queues that do not exist
    queue_word(mqpd_pkg::CMD_REMOVE, 0, 0, 1'b0);
    queue_word(mqpd_pkg::CMD_REMOVE, 5, 9, 1'b0);
    queue_word(mqpd_pkg::CMD_REMOVE, 7, 15, 1'b0);
    // Inserts into queues that do not exist are refused
    queue_word(mqpd_pkg::CMD_INSERT, 5, 3, 1'b0);
    queue_word(mqpd_pkg::CMD_INSERT, 7, 15, 1'b0);
    // Priority extremes and a tie on the top priority
    queue_word(mqpd_pkg::CMD_INSERT, 0, 0, 1'b0);
    queue_word(mqpd_pkg::CMD_INSERT, 0, 15, 1'b0);
    queue_word(mqpd_pkg::CMD_INSERT, 0, 15, 1'b0);
    queue_word(mqpd_pkg::CMD_INSERT, 0, 7, 1'b0);
    queue_word(mqpd_pkg::CMD_INSERT, 4, 10, 1'b0);
    for (int i = 0; i < 5; i++) queue_word(mqpd_pkg::CMD_REMOVE, 0, 15 - i, 1'b0);
    queue_word(mqpd_pkg::CMD_REMOVE, 4, 0, 1'b0);
    // Random bursts; a few open with a drain pause
    round = 0;
    while (feed_q.size() < RAND_WORDS + 16) begin
      mode     = $urandom_range(0, 3);
      q        = pick_queue();
      len      = $urandom_range(1, 22);
      tie_prio = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < len; i++) begin
        bit drain;
        drain = (i == 0) && (round % 12 == 5);
        case (mode)
          0, 1: begin
            // Fill one queue, often past full
            queue_word(mqpd_pkg::CMD_INSERT, q,
                       tie_prio ? 15 * $urandom_range(0, 1) : $urandom_range(0, 15), drain);
          end
          2: begin
            // Drain one queue, often past empty
            queue_word(mqpd_pkg::CMD_REMOVE, q, $urandom_range(0, 15), drain);
          end
          default: begin
            queue_word(1'($urandom_range(0, 1)), pick_queue(), $urandom_range(0, 15), drain);
          end
        endcase
      end
      round++;
    end
    words_total = feed_q.size();
  endtask

  // Driver: hold a word until it is taken, then offer the next or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      // hold
    end else if (feed_q.size() == 0) begin
      start <= 1'b0;
    end else if (feed_q[0].drain && result_due.size() != 0) begin
      start <= 1'b0;
    end else if ((words_offered < 500 || words_offered > 1100) &&
                 $urandom_range(0, 99) < 23) begin
      start <= 1'b0;
    end else begin
      feed_t f;
      f = feed_q.pop_front();
      in_word       <= f.word;
      start         <= 1'b1;
      words_offered <= words_offered + 1;
    end
  end

  // Monitor: check each result word, then record the word taken at this edge
  always @(posedge clk) begin
    if (!rst_n) begin
      taken <= 1'b0;
    end else begin
      if (out_valid) begin
        if (result_due.size() == 0) begin
          $error("result word with nothing expected: status %0d job %0d",
                 out_word.status, out_word.job_number);
          mismatches++;
        end else begin
          mqpd_pkg::out_word_t e;
          e = result_due.pop_front();
          if (out_word.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_word.status);
            mismatches++;
          end
          if (out_word.job_number !== e.job_number) begin
            $error("job_number: expected %0d, got %0d", e.job_number, out_word.job_number);
            mismatches++;
          end
          case (e.status)
            mqpd_pkg::ST_INSERTED: n_inserted++;
            mqpd_pkg::ST_REMOVED:  n_removed++;
            mqpd_pkg::ST_EMPTY:    n_empty++;
            default:               n_full++;
          endcase
        end
      end
      taken <= start && !busy;
      if (start && !busy) begin
        mqpd_pkg::out_word_t p;
        p          = dispatch_predict(in_word);
        result_due = {result_due, p};
        words_taken++;
      end
    end
  end

  // Watchdog: stop when nothing moves for too long, or the run overstays
  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run >= RUN_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Sequence: reset, run all words, drain, report
  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_word       = '0;
    taken         = 1'b0;
    words_taken   = 0;
    words_offered = 0;
    mismatches    = 0;
    n_inserted    = 0;
    n_removed     = 0;
    n_empty       = 0;
    n_full        = 0;
    quiet_cycles  = 0;
    cycles_run    = 0;
    next_arrival  = 32'd1;
    for (int q = 0; q < NQ; q++) begin
      queue_count[q] = 0;
      for (int i = 0; i < DEPTH; i++) slot_used[q][i] = 1'b0;
    end
    build_stimulus();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (!(words_taken == words_total && result_due.size() == 0)) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Ran %0d words: %0d inserted, %0d removed, %0d empty, %0d refused.",
             words_taken, n_inserted, n_removed, n_empty, n_full);
    $display("Last arrival number handed out: %0d", next_arrival - 32'd1);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
